// ===== src/windowed_peak_kalman_smoother_unit_assert.svh =====
// Assertion macros used by the smoother back part
`ifndef WINDOWED_PEAK_KALMAN_SMOOTHER_UNIT_ASSERT_SVH
`define WINDOWED_PEAK_KALMAN_SMOOTHER_UNIT_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset
`define WPKS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, clocked on clk, off during reset
`define WPKS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== src/wpks_pkg.sv =====
// Shared types and constants of the windowed peak Kalman smoother
`default_nettype none
package wpks_pkg;
    localparam int CH_BITS       = 4;
    localparam int SMP_BITS      = 12;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;
    localparam int CNT_BITS      = 8;
    localparam int NOISE_BITS    = 16;
    localparam int EST_BITS      = 24;
    localparam int COV_BITS      = 24;
    localparam int GAIN_BITS     = 16;
    localparam int DIV_STEPS     = 17;

    localparam logic [CFG_IDX_BITS-1:0] REG_BASE = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_Q    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_R    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_WIN  = 3'd3;

    localparam logic [SMP_BITS-1:0]   BASE_RST = 12'd3900;
    localparam logic [NOISE_BITS-1:0] Q_RST    = 16'd26;
    localparam logic [NOISE_BITS-1:0] R_RST    = 16'd1280;
    localparam logic [CNT_BITS-1:0]   WIN_RST  = 8'd10;
    localparam logic [COV_BITS-1:0]   COV_RST  = 24'h010000;

    typedef struct packed {
        logic [SMP_BITS-1:0]   base_offset;
        logic [NOISE_BITS-1:0] process_noise;
        logic [NOISE_BITS-1:0] measure_noise;
        logic [CNT_BITS-1:0]   window_len;
    } cfg_t;

    typedef struct packed {
        logic [CH_BITS-1:0]  channel;
        logic [SMP_BITS-1:0] peak;
        logic [SMP_BITS-1:0] meas;
    } win_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;
endpackage
`default_nettype wire

// ===== src/wpks_channels_if.sv =====
// Request channel interfaces for samples in and window results out
`default_nettype none
interface wpks_in_if import wpks_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CH_BITS-1:0]  channel;
    logic [SMP_BITS-1:0] sample;
    modport source (output valid, channel, sample, input ready);
    modport sink   (input valid, channel, sample, output ready);
endinterface

interface wpks_out_if import wpks_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CH_BITS-1:0]  out_channel;
    logic [SMP_BITS-1:0] filtered_value;
    logic [SMP_BITS-1:0] peak_value;
    modport source (output valid, out_channel, filtered_value, peak_value, input ready);
    modport sink   (input valid, out_channel, filtered_value, peak_value, output ready);
endinterface
`default_nettype wire

// ===== src/windowed_peak_kalman_smoother_unit.sv =====
// Top level: configuration registers, window front, queue and Kalman back
// The front takes a new sample only after the update of the last one retires;
// the back takes a closed window only after the last result is stored, using
// the 17-step serial gain divider.
// A two-entry queue lets the front run ahead of the back.
// Reset (rst_n low, asynchronous) restores register defaults and clears all
// channel state through valid bits; no clearing pass is needed.
`default_nettype none
module windowed_peak_kalman_smoother_unit import wpks_pkg::*; #(
    parameter int CHANNELS    = 12,
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
    wpks_in_if.sink                       samples,
    wpks_out_if.source                    results
);
    cfg_t       cfg_reg;
    logic       push;
    logic       pop;
    win_item_t  push_item;
    win_item_t  pop_item;
    fifo_stat_t fstat;

    // Write configuration registers; drop writes to unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_offset   <= BASE_RST;
            cfg_reg.process_noise <= Q_RST;
            cfg_reg.measure_noise <= R_RST;
            cfg_reg.window_len    <= WIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BASE: cfg_reg.base_offset   <= cfg_data[SMP_BITS-1:0];
                REG_Q:    cfg_reg.process_noise <= cfg_data[NOISE_BITS-1:0];
                REG_R:    cfg_reg.measure_noise <= cfg_data[NOISE_BITS-1:0];
                REG_WIN:  cfg_reg.window_len    <= cfg_data[CNT_BITS-1:0];
                default:  ;
            endcase
        end
    end

    wpks_front #(.CHANNELS(CHANNELS), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples),
        .cfg       (cfg_reg),
        .fstat     (fstat),
        .push      (push),
        .push_item (push_item)
    );

    wpks_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .fstat     (fstat)
    );

    wpks_back #(.CHANNELS(CHANNELS), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .fstat    (fstat),
        .pop      (pop),
        .pop_item (pop_item),
        .results  (results)
    );
endmodule
`default_nettype wire

// ===== src/wpks_front.sv =====
// Front part: per-channel window peak and count, queues closed windows
`default_nettype none
module wpks_front import wpks_pkg::*; #(
    parameter int CHANNELS    = 12,
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    wpks_in_if.sink     samples,
    input  cfg_t        cfg,
    input  fifo_stat_t  fstat,
    output logic        push,
    output win_item_t   push_item
);
    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [SMP_BITS-1:0] SMASK = SMP_BITS'((32'd1 << SAMPLE_BITS) - 32'd1);

    typedef struct packed {
        logic [CNT_BITS-1:0] count;
        logic [SMP_BITS-1:0] peak;
    } win_t;

    typedef enum logic {F_IDLE, F_UPD} state_t;

    win_t                mem [CHANNELS];
    logic [CHANNELS-1:0] vld_reg;
    win_t                rd_reg;
    logic                rd_vld_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [CH_BITS-1:0]  ch_reg;
    logic [SMP_BITS-1:0] smp_reg;
    state_t              state_reg;

    logic                accept;
    logic                ch_ok;
    logic [IDX_W-1:0]    idx;
    logic [SMP_BITS-1:0] cur_peak;
    logic [CNT_BITS-1:0] cur_cnt;
    logic [SMP_BITS-1:0] new_peak;
    logic [CNT_BITS-1:0] new_cnt;
    logic                close;
    logic                done;

    // Take a request only when no sample is being updated
    assign samples.ready = (state_reg == F_IDLE);
    assign accept = samples.valid && samples.ready;
    assign ch_ok  = 32'(samples.channel) < CHANNELS;
    assign idx    = IDX_W'(samples.channel);

    // Update the window of the held sample
    always_comb
    begin
        cur_peak = rd_vld_reg ? rd_reg.peak  : '0;
        cur_cnt  = rd_vld_reg ? rd_reg.count : '0;
        new_peak = (smp_reg > cur_peak) ? smp_reg : cur_peak;
        new_cnt  = cur_cnt + 8'd1;
        close    = !(new_cnt < cfg.window_len);
        done     = (state_reg == F_UPD) && (!close || !fstat.full);
        push     = (state_reg == F_UPD) && close && !fstat.full;
        push_item.channel = ch_reg;
        push_item.peak    = new_peak;
        push_item.meas    = (new_peak > cfg.base_offset) ? (new_peak - cfg.base_offset) : '0;
    end

    // Window store: read on accept, write back when the update retires
    always_ff @(posedge clk)
    begin
        if (accept && ch_ok)
        begin
            rd_reg <= mem[idx];
        end
        if (done)
        begin
            mem[idx_reg] <= close ? win_t'('0) : win_t'{count: new_cnt, peak: new_peak};
        end
    end

    // Hold state, valid bits and the captured request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_IDLE;
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
            idx_reg    <= '0;
            ch_reg     <= '0;
            smp_reg    <= '0;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (accept && ch_ok)
                    begin
                        rd_vld_reg <= vld_reg[idx];
                        idx_reg    <= idx;
                        ch_reg     <= samples.channel;
                        smp_reg    <= samples.sample & SMASK;
                        state_reg  <= F_UPD;
                    end
                end
                F_UPD:
                begin
                    if (done)
                    begin
                        vld_reg[idx_reg] <= 1'b1;
                        state_reg        <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== src/wpks_fifo.sv =====
// Two-entry queue of closed windows between front and back
`default_nettype none
module wpks_fifo import wpks_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  win_item_t       push_item,
    input  wire logic       pop,
    output win_item_t       pop_item,
    output fifo_stat_t      fstat
);
    win_item_t  entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign pop_item    = entry_reg[rd_ptr_reg];
    assign fstat.full  = (count_reg == 2'd2);
    assign fstat.empty = (count_reg == 2'd0);

    // Store the pushed window
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end
endmodule
`default_nettype wire

// ===== src/wpks_back.sv =====
// Back part: per-channel scalar Kalman update with a serial gain divider
`default_nettype none
`include "windowed_peak_kalman_smoother_unit_assert.svh"
module wpks_back import wpks_pkg::*; #(
    parameter int CHANNELS    = 12,
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  cfg_t        cfg,
    input  fifo_stat_t  fstat,
    output logic        pop,
    input  win_item_t   pop_item,
    wpks_out_if.source  results
);
    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [16:0] SAT_MAX = 17'((32'd1 << SAMPLE_BITS) - 32'd1);

    typedef enum logic [2:0] {B_IDLE, B_LOAD, B_DIV, B_MULX, B_MULP, B_UPD} state_t;

    logic [EST_BITS-1:0] x_mem [CHANNELS];
    logic [COV_BITS-1:0] p_mem [CHANNELS];
    logic [CHANNELS-1:0] vld_reg;
    logic [EST_BITS-1:0] x_rd_reg;
    logic [COV_BITS-1:0] p_rd_reg;
    logic                rd_vld_reg;
    win_item_t           item_reg;
    logic [IDX_W-1:0]    idx_reg;
    state_t              state_reg;

    logic [EST_BITS-1:0] x_reg;
    logic [COV_BITS-1:0] p1_reg;
    logic [24:0]         d_reg;
    logic [24:0]         rem_reg;
    logic                lsb_reg;
    logic [16:0]         q_reg;
    logic [4:0]          cnt_reg;
    logic [GAIN_BITS-1:0] k_reg;
    logic                up_reg;
    logic [39:0]         prodx_reg;
    logic [40:0]         prodp_reg;
    logic [EST_BITS-1:0] x_new_reg;

    logic                out_valid_reg;
    logic [CH_BITS-1:0]  out_ch_reg;
    logic [SMP_BITS-1:0] out_filt_reg;
    logic [SMP_BITS-1:0] out_peak_reg;

    logic [EST_BITS-1:0] x0;
    logic [COV_BITS-1:0] p0;
    logic [24:0]         p1_sum;
    logic [COV_BITS-1:0] p1;
    logic [24:0]         d;
    logic [25:0]         t;
    logic                ge;
    logic [GAIN_BITS-1:0] k;
    logic [EST_BITS-1:0] m;
    logic [EST_BITS-1:0] mag;
    logic [COV_BITS-1:0] p_new;
    logic [12:0]         rnd;
    logic [SMP_BITS-1:0] filt;
    logic                upd_go;

    assign pop    = (state_reg == B_IDLE) && !fstat.empty;
    assign upd_go = (state_reg == B_UPD) && (!out_valid_reg || results.ready);

    assign results.valid          = out_valid_reg;
    assign results.out_channel    = out_ch_reg;
    assign results.filtered_value = out_filt_reg;
    assign results.peak_value     = out_peak_reg;

    // Predict covariance, form gain divisor, one divider step, update terms
    always_comb
    begin
        x0     = rd_vld_reg ? x_rd_reg : '0;
        p0     = rd_vld_reg ? p_rd_reg : COV_RST;
        p1_sum = {1'b0, p0} + {1'b0, cfg.process_noise, 8'd0};
        p1     = p1_sum[24] ? {COV_BITS{1'b1}} : p1_sum[COV_BITS-1:0];
        d      = {1'b0, p1} + {1'b0, cfg.measure_noise, 8'd0};
        t      = {rem_reg, (cnt_reg == 5'd0) ? lsb_reg : 1'b0};
        ge     = t >= {1'b0, d_reg};
        if (d_reg == '0)
        begin
            k = '0;
        end
        else if (q_reg[16])
        begin
            k = {GAIN_BITS{1'b1}};
        end
        else
        begin
            k = q_reg[GAIN_BITS-1:0];
        end
        m     = {item_reg.meas, 12'd0};
        mag   = (m >= x_reg) ? (m - x_reg) : (x_reg - m);
        p_new = prodp_reg[39:16];
        rnd   = 13'(({1'b0, x_new_reg} + 25'd2048) >> 12);
        filt  = ({4'd0, rnd} > SAT_MAX) ? SAT_MAX[SMP_BITS-1:0] : rnd[SMP_BITS-1:0];
    end

    // Channel state store: read on pop, write when the update retires
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            x_rd_reg <= x_mem[IDX_W'(pop_item.channel)];
            p_rd_reg <= p_mem[IDX_W'(pop_item.channel)];
        end
        if (upd_go)
        begin
            x_mem[idx_reg] <= x_new_reg;
            p_mem[idx_reg] <= p_new;
        end
    end

    // Hold state, datapath registers and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            vld_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            // Drop the result once taken, unless a new one replaces it
            if (results.valid && results.ready && !upd_go)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE:
                begin
                    if (pop)
                    begin
                        item_reg   <= pop_item;
                        idx_reg    <= IDX_W'(pop_item.channel);
                        rd_vld_reg <= vld_reg[IDX_W'(pop_item.channel)];
                        state_reg  <= B_LOAD;
                    end
                end
                B_LOAD:
                begin
                    x_reg     <= x0;
                    p1_reg    <= p1;
                    d_reg     <= d;
                    rem_reg   <= {2'b0, p1[COV_BITS-1:1]};
                    lsb_reg   <= p1[0];
                    q_reg     <= '0;
                    cnt_reg   <= '0;
                    state_reg <= B_DIV;
                end
                B_DIV:
                begin
                    rem_reg <= ge ? 25'(t - {1'b0, d_reg}) : t[24:0];
                    q_reg   <= {q_reg[15:0], ge};
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'(DIV_STEPS - 1))
                    begin
                        state_reg <= B_MULX;
                    end
                end
                B_MULX:
                begin
                    k_reg     <= k;
                    up_reg    <= (m >= x_reg);
                    prodx_reg <= 40'(k) * 40'(mag);
                    state_reg <= B_MULP;
                end
                B_MULP:
                begin
                    prodp_reg <= 41'(17'h10000 - {1'b0, k_reg}) * 41'(p1_reg);
                    x_new_reg <= up_reg ? (x_reg + prodx_reg[39:16])
                                        : (x_reg - prodx_reg[39:16]);
                    state_reg <= B_UPD;
                end
                B_UPD:
                begin
                    if (upd_go)
                    begin
                        vld_reg[idx_reg] <= 1'b1;
                        out_valid_reg    <= 1'b1;
                        out_ch_reg       <= item_reg.channel;
                        out_filt_reg     <= filt;
                        out_peak_reg     <= item_reg.peak;
                        state_reg        <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    `WPKS_ASSERT_IMPL(a_div_count, state_reg == B_DIV, cnt_reg <= 5'(DIV_STEPS - 1))
    `WPKS_ASSERT_NEXT(a_load_to_div, state_reg == B_LOAD, state_reg == B_DIV)
    `WPKS_ASSERT_NEXT(a_pop_to_load, pop, state_reg == B_LOAD)
    `WPKS_ASSERT_NEXT(a_upd_sets_out, upd_go, out_valid_reg)
endmodule
`default_nettype wire

// ===== tb/sv/windowed_peak_kalman_smoother_unit_tb.sv =====
// Self-checking testbench for the windowed peak Kalman smoother unit
`default_nettype none
module windowed_peak_kalman_smoother_unit_tb;
    import wpks_pkg::*;

    localparam int NUM_CH     = 12;
    localparam int CYCLE_MAX  = 400000;
    localparam int DRAIN_WAIT = 40;
    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;

    typedef enum logic {ROW_CFG, ROW_SMP} row_kind_t;

    typedef struct {
        logic [CH_BITS-1:0]  ch;
        logic [SMP_BITS-1:0] filt;
        logic [SMP_BITS-1:0] peak;
    } window_res_t;

    typedef struct {
        row_kind_t                kind;
        logic [CFG_IDX_BITS-1:0]  idx;
        logic [CFG_DATA_BITS-1:0] data;
        logic [CH_BITS-1:0]       ch;
        logic [SMP_BITS-1:0]      smp;
        bit                       has_exp;
        window_res_t              exp_res;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    wpks_in_if  samples ();
    wpks_out_if results ();

    windowed_peak_kalman_smoother_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (samples),
        .results   (results)
    );

    // Predictor copy of registers and per-channel state
    logic [SMP_BITS-1:0]   m_base;
    logic [NOISE_BITS-1:0] m_q;
    logic [NOISE_BITS-1:0] m_r;
    logic [CNT_BITS-1:0]   m_win;
    logic [CNT_BITS-1:0]   m_cnt  [NUM_CH];
    logic [SMP_BITS-1:0]   m_peak [NUM_CH];
    logic [EST_BITS-1:0]   m_x    [NUM_CH];
    logic [COV_BITS-1:0]   m_p    [NUM_CH];

    window_res_t pending_windows [$];
    int  mismatches;
    int  cycles;
    bit  no_idle;
    int  rx_hold;

    // Apply one register write to the predictor
    function automatic void apply_reg_write(logic [CFG_IDX_BITS-1:0] idx,
                                            logic [CFG_DATA_BITS-1:0] data);
        case (idx)
            REG_BASE: m_base = data[SMP_BITS-1:0];
            REG_Q:    m_q    = data;
            REG_R:    m_r    = data;
            REG_WIN:  m_win  = data[CNT_BITS-1:0];
            default:  ;
        endcase
    endfunction

    // Advance one channel by a sample; return 1 when its window closes
    function automatic bit predict_window(logic [CH_BITS-1:0] ch,
                                          logic [SMP_BITS-1:0] smp,
                                          output window_res_t res);
        logic [63:0] p1, den, gain, x, m, rnd;
        logic [SMP_BITS-1:0] pk, meas;
        res = '{default: '0};
        if (ch >= NUM_CH)
            return 0;
        if (smp > m_peak[ch])
            m_peak[ch] = smp;
        m_cnt[ch] = m_cnt[ch] + 1'b1;
        if (m_cnt[ch] < m_win)
            return 0;
        pk   = m_peak[ch];
        meas = (pk > m_base) ? pk - m_base : '0;
        p1 = 64'(m_p[ch]) + (64'(m_q) << 8);
        if (p1 > 64'hFFFFFF)
            p1 = 64'hFFFFFF;
        den = p1 + (64'(m_r) << 8);
        if (den == 0)
            gain = 0;
        else
        begin
            gain = (p1 << 16) / den;
            if (gain > 64'd65535)
                gain = 64'd65535;
        end
        x = 64'(m_x[ch]);
        m = 64'(meas) << 12;
        // Move toward the measurement, truncating the step toward zero
        if (m >= x)
            x = x + ((gain * (m - x)) >> 16);
        else
            x = x - ((gain * (x - m)) >> 16);
        m_x[ch] = x[EST_BITS-1:0];
        m_p[ch] = COV_BITS'(((64'd65536 - gain) * p1) >> 16);
        rnd = (x + 64'd2048) >> 12;
        if (rnd > 64'd4095)
            rnd = 64'd4095;
        m_peak[ch] = '0;
        m_cnt[ch]  = '0;
        res.ch   = ch;
        res.filt = rnd[SMP_BITS-1:0];
        res.peak = pk;
        return 1;
    endfunction

    // Clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // Timeout
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_MAX)
        begin
            $display("FAIL windowed_peak_kalman_smoother_unit");
            $finish;
        end
    end

    // Result receiver: random stalls, plus a long hold when requested
    initial
    begin
        int stall;
        results.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                results.ready <= 1'b0;
                repeat (rx_hold) @(negedge clk);
                rx_hold = 0;
            end
            stall = no_idle ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                results.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            results.ready <= 1'b1;
            do @(posedge clk); while (!results.valid);
        end
    end

    // Check each accepted result against the oldest expectation
    always @(posedge clk)
    begin
        window_res_t e;
        if (rst_n && results.valid && results.ready)
        begin
            if (pending_windows.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result ch=%0d filt=%0d peak=%0d",
                             results.out_channel, results.filtered_value,
                             results.peak_value);
            end
            else
            begin
                e = pending_windows.pop_front();
                if (results.out_channel !== e.ch || results.filtered_value !== e.filt
                    || results.peak_value !== e.peak)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp ch=%0d filt=%0d peak=%0d, got ch=%0d filt=%0d peak=%0d",
                                 e.ch, e.filt, e.peak, results.out_channel,
                                 results.filtered_value, results.peak_value);
                end
            end
        end
    end

    // Offer one sample request and predict on acceptance
    task automatic send_sample(logic [CH_BITS-1:0] ch, logic [SMP_BITS-1:0] smp,
                               bit has_exp, window_res_t exp_res);
        int gap;
        window_res_t res;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            samples.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        samples.valid   <= 1'b1;
        samples.channel <= ch;
        samples.sample  <= smp;
        do @(posedge clk); while (!samples.ready);
        if (predict_window(ch, smp, res))
            pending_windows.push_back(has_exp ? exp_res : res);
        @(negedge clk);
    endtask

    // Drop valid and wait until every expected result has arrived
    task automatic drain_results();
        samples.valid <= 1'b0;
        while (pending_windows.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    // Write one register while the block is idle
    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx,
                             logic [CFG_DATA_BITS-1:0] data);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        apply_reg_write(idx, data);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Random sample: mostly valid channels, some ignored ones
    task automatic send_random(int ch_hi);
        logic [CH_BITS-1:0]  ch;
        logic [SMP_BITS-1:0] smp;
        ch = ($urandom_range(0, 15) == 0) ? CH_BITS'($urandom_range(12, 15))
                                          : CH_BITS'($urandom_range(0, ch_hi));
        case ($urandom_range(0, 5))
            0:       smp = 12'd4095;
            1:       smp = 12'd0;
            2:       smp = SMP_BITS'(m_base + $urandom_range(0, 64) - 32);
            default: smp = SMP_BITS'($urandom);
        endcase
        send_sample(ch, smp, 1'b0, '{default: '0});
    endtask

    stim_row_t dir_tab [24];

    initial
    begin
        int n_items;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        samples.valid = 1'b0;
        samples.channel = '0;
        samples.sample  = '0;
        mismatches = 0;
        cycles     = 0;
        no_idle    = 1'b0;
        rx_hold    = 0;
        m_base = BASE_RST;
        m_q    = Q_RST;
        m_r    = R_RST;
        m_win  = WIN_RST;
        for (int i = 0; i < NUM_CH; i++)
        begin
            m_cnt[i]  = '0;
            m_peak[i] = '0;
            m_x[i]    = '0;
            m_p[i]    = COV_RST;
        end

        // Extremes, ignored channels, degenerate gain, short and zero windows
        dir_tab = '{
            '{ROW_CFG, REG_BASE,   16'd0,      4'd0,  12'd0,    1'b0, '{4'd0, 12'd0, 12'd0}},
            '{ROW_CFG, REG_Q,      16'd0,      4'd0,  12'd0,    1'b0, '{4'd0, 12'd0, 12'd0}},
            '{ROW_CFG, REG_R,      16'd0,      4'd0,  12'd0,    1'b0, '{4'd0, 12'd0, 12'd0}},
            '{ROW_CFG, REG_WIN,    16'd1,      4'd0,  12'd0,    1'b0, '{4'd0, 12'd0, 12'd0}},
            '{ROW_SMP, REG_BASE,   16'd0,      4'd15, 12'd4095, 1'b0, '{4'd0, 12'd0, 12'd0}},
            '{ROW_SMP, REG_BASE,   16'd0,      4'd12, 12'd0,    1'b0, '{4'd0, 12'd0, 12'd0}},
            '{ROW_SMP, REG_BASE,   16'd0,      4'd0,  12'd4095, 1'b1, '{4'd0, 12'd4095, 12'd4095}},
            '{ROW_SMP, REG_BASE,   16'd0,      4'd1,  12'd0,    1'b1, '{4'd1, 12'd0, 12'd0}},
            '{ROW_SMP, REG_BASE,   16'd0,      4'd0,  12'd0,    1'b0, '{4'd0, 12'd0, 12'd0}},
            '{ROW_SMP, REG_BASE,   16'd0,      4'd0,  12'd2048, 1'b0, '{4'd0, 12'd0, 12'd0}},
            '{ROW_SMP, REG_BASE,   16'd0,      4'd0,  12'd1,    1'b0, '{4'd0, 12'd0, 12'd0}},
            '{ROW_CFG, REG_UNUSED, 16'hFFFF,   4'd0,  12'd0,    1'b0, '{4'd0, 12'd0, 12'd0}},
            '{ROW_CFG, REG_WIN,    16'h0100,   4'd0,  12'd0,    1'b0, '{4'd0, 12'd0, 12'd0}},
            '{ROW_SMP, REG_BASE,   16'd0,      4'd2,  12'd100,  1'b0, '{4'd0, 12'd0, 12'd0}},
            '{ROW_CFG, REG_WIN,    16'd5,      4'd0,  12'd0,    1'b0, '{4'd0, 12'd0, 12'd0}},
            '{ROW_SMP, REG_BASE,   16'd0,      4'd3,  12'd700,  1'b0, '{4'd0, 12'd0, 12'd0}},
            '{ROW_SMP, REG_BASE,   16'd0,      4'd3,  12'd2900, 1'b0, '{4'd0, 12'd0, 12'd0}},
            '{ROW_SMP, REG_BASE,   16'd0,      4'd3,  12'd5,    1'b0, '{4'd0, 12'd0, 12'd0}},
            '{ROW_CFG, REG_WIN,    16'd2,      4'd0,  12'd0,    1'b0, '{4'd0, 12'd0, 12'd0}},
            '{ROW_SMP, REG_BASE,   16'd0,      4'd3,  12'd10,   1'b0, '{4'd0, 12'd0, 12'd0}},
            '{ROW_CFG, REG_BASE,   16'hFFFF,   4'd0,  12'd0,    1'b0, '{4'd0, 12'd0, 12'd0}},
            '{ROW_CFG, REG_R,      16'hFFFF,   4'd0,  12'd0,    1'b0, '{4'd0, 12'd0, 12'd0}},
            '{ROW_CFG, REG_Q,      16'hFFFF,   4'd0,  12'd0,    1'b0, '{4'd0, 12'd0, 12'd0}},
            '{ROW_SMP, REG_BASE,   16'd0,      4'd11, 12'd4095, 1'b0, '{4'd0, 12'd0, 12'd0}}
        };

        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Walk the directed table
        foreach (dir_tab[i])
        begin
            if (dir_tab[i].kind == ROW_CFG)
                write_reg(dir_tab[i].idx, dir_tab[i].data);
            else
                send_sample(dir_tab[i].ch, dir_tab[i].smp, dir_tab[i].has_exp,
                            dir_tab[i].exp_res);
        end

        // Random phases, each under its own register setting
        for (int ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(REG_BASE, 16'd3900);
                    write_reg(REG_Q, 16'd26);
                    write_reg(REG_R, 16'd1280);
                    write_reg(REG_WIN, 16'd1);
                end
                1: write_reg(REG_WIN, 16'd255);
                2:
                begin
                    write_reg(REG_WIN, 16'd3);
                    write_reg(REG_BASE, 16'd0);
                end
                3:
                begin
                    write_reg(REG_R, 16'd1);
                    write_reg(REG_Q, 16'd0);
                end
                default:
                begin
                    write_reg(REG_BASE, CFG_DATA_BITS'($urandom));
                    write_reg(REG_Q, CFG_DATA_BITS'($urandom));
                    write_reg(REG_R, CFG_DATA_BITS'($urandom_range(1, 65535)));
                    write_reg(REG_WIN, CFG_DATA_BITS'($urandom_range(1, 4)));
                end
            endcase
            no_idle = (ph == 3);
            // Long receiver hold while the sender keeps pushing
            if (ph == 2)
                rx_hold = 300;
            n_items = (ph == 1) ? 40 : 80;
            for (int k = 0; k < n_items; k++)
            begin
                // Pause until the block has delivered everything
                if (ph == 4 && k == 40)
                    drain_results();
                send_random((ph == 1) ? 3 : NUM_CH - 1);
            end
        end
        no_idle = 1'b0;

        drain_results();
        if (mismatches == 0)
            $display("PASS windowed_peak_kalman_smoother_unit");
        else
            $display("FAIL windowed_peak_kalman_smoother_unit");
        $finish;
    end
endmodule
`default_nettype wire
